>>> rtl/core/ssl_pkg.sv
// ----------------------------------------------------------------------------
// ssl_pkg: shared types and constants of the s-record stream loader
// operation codes between front and back, result layout, buffer geometry
// ----------------------------------------------------------------------------
`default_nettype none

package ssl_pkg;

   // buffer geometry
   localparam int BUF_BITS = 20;
   localparam logic [BUF_BITS-1:0] BUF_MASK = {BUF_BITS{1'b1}};
   localparam logic [BUF_BITS:0]   BUF_SIZE = {1'b1, {BUF_BITS{1'b0}}};

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // characters of interest
   localparam logic [7:0] CHAR_S    = 8'h53;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_S3   = 8'h33;
   localparam logic [7:0] CHAR_S7   = 8'h37;

   // operation codes handed from front to back
   localparam logic [2:0] OP_WRITE  = 3'd0;
   localparam logic [2:0] OP_ORIGIN = 3'd1;
   localparam logic [2:0] OP_ENTRY  = 3'd2;
   localparam logic [2:0] OP_RECORD = 3'd3;
   localparam logic [2:0] OP_ABORT  = 3'd4;
   localparam logic [2:0] OP_CLEAR  = 3'd5;

   // result kinds
   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_RECORD = 2'd1;
   localparam logic [1:0] KIND_LOAD   = 2'd2;
   localparam logic [1:0] KIND_ABORT  = 2'd3;

   // data: byte in [7:0] for writes, address for origin/entry,
   // {calc, recv} in [15:0] for record ends
   typedef struct packed {
      logic [2:0]  code;
      logic [7:0]  type_char;
      logic [31:0] data;
      logic        sum_ok;
      logic        last;
      logic        len_bad;
   } op_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [BUF_BITS-1:0] write_offset;
      logic [7:0]          write_byte;
      logic [7:0]          record_type;
      logic [7:0]          sum_calc;
      logic [7:0]          sum_recv;
      logic                sum_ok;
      logic [31:0]         entry_point;
      logic [BUF_BITS-1:0] low_mark;
      logic [BUF_BITS:0]   high_mark;
      logic                end_length_bad;
      logic [15:0]         record_number;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/ssl_front.sv
// ----------------------------------------------------------------------------
// ssl_front: character parser
// pairs hex digits into bytes, tracks the record phase, emits operations
// ----------------------------------------------------------------------------
`default_nettype none

module ssl_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            take,
   input  wire logic            cmd,
   input  wire logic [7:0]      text_char,
   output logic                 push_valid,
   output ssl_pkg::op_type      push_op
);

   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_TYPE = 3'd1;
   localparam logic [2:0] PH_LEN  = 3'd2;
   localparam logic [2:0] PH_ADDR = 3'd3;
   localparam logic [2:0] PH_BODY = 3'd4;
   localparam logic [2:0] PH_CSUM = 3'd5;
   localparam logic [2:0] PH_STOP = 3'd6;

   // {valid, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'b0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      return r;
   endfunction

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  high_nib_ff, high_nib_in;
   logic        pending_ff, pending_in;
   logic [7:0]  pairs_ff, pairs_in;
   logic [2:0]  addr_cnt_ff, addr_cnt_in;
   logic [31:0] acc_ff, acc_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  type_ff, type_in;
   logic        bad_ff, bad_in;

   logic [4:0]  hex;
   logic [3:0]  digit;
   logic        bad_next;
   logic [7:0]  byte_val;
   logic [7:0]  calc;
   logic [31:0] acc_next;
   logic [2:0]  cnt_next;
   logic [7:0]  pairs_dec;

   assign hex       = hex_decode(text_char);
   assign digit     = hex[4] ? hex[3:0] : 4'd0;
   assign bad_next  = bad_ff | ~hex[4];
   assign byte_val  = {high_nib_ff, digit};
   assign calc      = ~sum_ff;
   assign acc_next  = {acc_ff[23:0], byte_val};
   assign cnt_next  = addr_cnt_ff + 3'd1;
   assign pairs_dec = (pairs_ff != 8'd0) ? pairs_ff - 8'd1 : 8'd0;

   always_comb begin
      phase_in    = phase_ff;
      high_nib_in = high_nib_ff;
      pending_in  = pending_ff;
      pairs_in    = pairs_ff;
      addr_cnt_in = addr_cnt_ff;
      acc_in      = acc_ff;
      sum_in      = sum_ff;
      type_in     = type_ff;
      bad_in      = bad_ff;
      push_valid  = 1'b0;
      push_op     = '0;
      push_op.type_char = type_ff;

      if (take && cmd) begin
         phase_in    = PH_HUNT;
         high_nib_in = 4'd0;
         pending_in  = 1'b0;
         pairs_in    = 8'd0;
         addr_cnt_in = 3'd0;
         acc_in      = 32'd0;
         sum_in      = 8'd0;
         type_in     = 8'd0;
         bad_in      = 1'b0;
         push_valid  = 1'b1;
         push_op.code = ssl_pkg::OP_CLEAR;
      end else if (take) begin
         case (phase_ff)
            PH_HUNT: begin
               if (text_char == ssl_pkg::CHAR_S) begin
                  sum_in     = 8'd0;
                  bad_in     = 1'b0;
                  pending_in = 1'b0;
                  phase_in   = PH_TYPE;
               end
            end
            PH_TYPE: begin
               type_in  = text_char;
               phase_in = PH_LEN;
            end
            PH_LEN, PH_ADDR, PH_BODY, PH_CSUM: begin
               bad_in = bad_next;
               if (!pending_ff) begin
                  high_nib_in = digit;
                  pending_in  = 1'b1;
               end else begin
                  pending_in = 1'b0;
                  if (phase_ff == PH_CSUM) begin
                     push_valid       = 1'b1;
                     push_op.code     = ssl_pkg::OP_RECORD;
                     push_op.data     = {16'd0, calc, byte_val};
                     push_op.sum_ok   = (calc == byte_val) && !bad_next;
                     push_op.last     = (type_ff == ssl_pkg::CHAR_S7);
                     push_op.len_bad  = (pairs_ff != 8'd0);
                     phase_in = (type_ff == ssl_pkg::CHAR_S7) ? PH_STOP : PH_HUNT;
                  end else begin
                     sum_in = sum_ff + byte_val;
                     if (phase_ff == PH_LEN) begin
                        if (bad_next) begin
                           push_valid   = 1'b1;
                           push_op.code = ssl_pkg::OP_ABORT;
                           phase_in     = PH_STOP;
                        end else if (type_ff == ssl_pkg::CHAR_ZERO) begin
                           pairs_in = (byte_val != 8'd0) ? byte_val - 8'd1 : 8'd0;
                           phase_in = (byte_val > 8'd1) ? PH_BODY : PH_CSUM;
                        end else if (type_ff == ssl_pkg::CHAR_S3 ||
                                     type_ff == ssl_pkg::CHAR_S7) begin
                           addr_cnt_in = 3'd0;
                           acc_in      = 32'd0;
                           if (type_ff == ssl_pkg::CHAR_S3)
                              pairs_in = (byte_val > 8'd5) ? byte_val - 8'd5 : 8'd0;
                           else
                              pairs_in = (byte_val != 8'd5) ? 8'd1 : 8'd0;
                           phase_in = PH_ADDR;
                        end else begin
                           phase_in = PH_CSUM;
                        end
                     end else if (phase_ff == PH_ADDR) begin
                        acc_in      = acc_next;
                        addr_cnt_in = cnt_next;
                        if (cnt_next >= 3'd4) begin
                           push_valid   = 1'b1;
                           push_op.data = acc_next;
                           if (type_ff == ssl_pkg::CHAR_S7) begin
                              push_op.code = ssl_pkg::OP_ENTRY;
                              phase_in     = PH_CSUM;
                           end else begin
                              push_op.code = ssl_pkg::OP_ORIGIN;
                              phase_in = (pairs_ff != 8'd0) ? PH_BODY : PH_CSUM;
                           end
                        end
                     end else begin
                        // body byte
                        pairs_in = pairs_dec;
                        if (pairs_dec == 8'd0) phase_in = PH_CSUM;
                        if (type_ff == ssl_pkg::CHAR_S3) begin
                           push_valid   = 1'b1;
                           push_op.code = ssl_pkg::OP_WRITE;
                           push_op.data = {24'd0, byte_val};
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         high_nib_ff <= 4'd0;
         pending_ff  <= 1'b0;
         pairs_ff    <= 8'd0;
         addr_cnt_ff <= 3'd0;
         acc_ff      <= 32'd0;
         sum_ff      <= 8'd0;
         type_ff     <= 8'd0;
         bad_ff      <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         high_nib_ff <= high_nib_in;
         pending_ff  <= pending_in;
         pairs_ff    <= pairs_in;
         addr_cnt_ff <= addr_cnt_in;
         acc_ff      <= acc_in;
         sum_ff      <= sum_in;
         type_ff     <= type_in;
         bad_ff      <= bad_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/ssl_queue.sv
// ----------------------------------------------------------------------------
// ssl_queue: operation queue
// small fifo that decouples the parser from the executing back end
// ----------------------------------------------------------------------------
`default_nettype none

module ssl_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push_valid,
   input  wire ssl_pkg::op_type push_op,
   output logic                 full,
   input  wire logic            pop,
   output logic                 q_valid,
   output ssl_pkg::op_type      q_op
);

   ssl_pkg::op_type entry_ff [ssl_pkg::QUEUE_DEPTH];
   logic [ssl_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ssl_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ssl_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   localparam logic [ssl_pkg::QUEUE_PTR_BITS-1:0] LAST_PTR =
      ssl_pkg::QUEUE_PTR_BITS'(ssl_pkg::QUEUE_DEPTH - 1);
   localparam logic [ssl_pkg::QUEUE_CNT_BITS-1:0] DEPTH_CNT =
      ssl_pkg::QUEUE_CNT_BITS'(ssl_pkg::QUEUE_DEPTH);

   assign full    = (count_ff == DEPTH_CNT);
   assign q_valid = (count_ff != '0);
   assign q_op    = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && !full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_op;
   end

endmodule

`default_nettype wire

>>> rtl/core/ssl_back.sv
// ----------------------------------------------------------------------------
// ssl_back: load executor
// applies queued operations to the write pointer and marks, registers results
// ----------------------------------------------------------------------------
`default_nettype none

module ssl_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            q_valid,
   input  wire ssl_pkg::op_type q_op,
   output logic                 pop,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output ssl_pkg::rsp_type     rsp
);

   logic [ssl_pkg::BUF_BITS-1:0] wp_ff, wp_in;
   logic [ssl_pkg::BUF_BITS-1:0] low_ff, low_in;
   logic [ssl_pkg::BUF_BITS:0]   high_ff, high_in;
   logic [15:0]                  rec_ff, rec_in;
   logic [31:0]                  entry_ff, entry_in;
   logic                         out_valid_ff, out_valid_in;
   ssl_pkg::rsp_type             res_ff, res_in;

   logic                         has_res;
   logic                         load_res;
   logic [ssl_pkg::BUF_BITS:0]   wp_end;
   logic [ssl_pkg::BUF_BITS:0]   wp_sat;
   logic [ssl_pkg::BUF_BITS-1:0] origin;
   logic [ssl_pkg::BUF_BITS:0]   origin_ext;

   assign has_res = (q_op.code == ssl_pkg::OP_WRITE) ||
                    (q_op.code == ssl_pkg::OP_RECORD) ||
                    (q_op.code == ssl_pkg::OP_ABORT);
   assign pop      = q_valid && (!has_res || !out_valid_ff || !rsp_stall);
   assign load_res = pop && has_res;

   assign wp_end     = {1'b0, wp_ff} + 1'b1;
   assign wp_sat     = (wp_end > ssl_pkg::BUF_SIZE) ? ssl_pkg::BUF_SIZE : wp_end;
   assign origin     = q_op.data[ssl_pkg::BUF_BITS-1:0];
   assign origin_ext = {1'b0, origin};

   always_comb begin
      wp_in    = wp_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      rec_in   = rec_ff;
      entry_in = entry_ff;
      res_in   = res_ff;
      out_valid_in = out_valid_ff && rsp_stall;

      if (pop) begin
         res_in = '0;
         res_in.record_type   = q_op.type_char;
         res_in.entry_point   = entry_ff;
         res_in.low_mark      = low_ff;
         res_in.high_mark     = high_ff;
         res_in.record_number = rec_ff;
         case (q_op.code)
            ssl_pkg::OP_WRITE: begin
               if (wp_sat > high_ff) high_in = wp_sat;
               wp_in = wp_ff + 1'b1;
               res_in.kind         = ssl_pkg::KIND_WRITE;
               res_in.write_offset = wp_ff;
               res_in.write_byte   = q_op.data[7:0];
               res_in.high_mark    = (wp_sat > high_ff) ? wp_sat : high_ff;
            end
            ssl_pkg::OP_ORIGIN: begin
               wp_in = origin;
               if (origin < low_ff) low_in = origin;
               if (origin_ext > high_ff) high_in = origin_ext;
            end
            ssl_pkg::OP_ENTRY: begin
               entry_in = q_op.data;
            end
            ssl_pkg::OP_RECORD: begin
               res_in.kind = q_op.last ? ssl_pkg::KIND_LOAD : ssl_pkg::KIND_RECORD;
               res_in.sum_calc       = q_op.data[15:8];
               res_in.sum_recv       = q_op.data[7:0];
               res_in.sum_ok         = q_op.sum_ok;
               res_in.end_length_bad = q_op.last && q_op.len_bad;
               rec_in = rec_ff + 16'd1;
            end
            ssl_pkg::OP_ABORT: begin
               res_in.kind = ssl_pkg::KIND_ABORT;
            end
            ssl_pkg::OP_CLEAR: begin
               wp_in    = '0;
               low_in   = ssl_pkg::BUF_MASK;
               high_in  = '0;
               rec_in   = 16'd1;
               entry_in = 32'd0;
            end
            default: begin
            end
         endcase
         if (!has_res) res_in = res_ff;
      end
      if (load_res) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         low_ff       <= ssl_pkg::BUF_MASK;
         high_ff      <= '0;
         rec_ff       <= 16'd1;
         entry_ff     <= 32'd0;
         out_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         rec_ff       <= rec_in;
         entry_ff     <= entry_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = res_ff;

   // the high mark never passes the buffer size
   assert property (@(posedge clock) disable iff (reset)
      high_ff <= ssl_pkg::BUF_SIZE)
      else $error("high mark beyond buffer size");

   // a clear leaves the marks at their reset values
   assert property (@(posedge clock) disable iff (reset)
      pop && q_op.code == ssl_pkg::OP_CLEAR |=>
         low_ff == ssl_pkg::BUF_MASK && high_ff == '0 && rec_ff == 16'd1)
      else $error("clear did not reset the marks");

   // a new result never overwrites one still held by a stall
   assert property (@(posedge clock) disable iff (reset)
      load_res |-> !(out_valid_ff && rsp_stall))
      else $error("held result overwritten");

endmodule

`default_nettype wire

>>> rtl/core/srecord_stream_loader.sv
// ----------------------------------------------------------------------------
// srecord_stream_loader: s-record text loader
// parses s0/s3/s7 records one character per beat and reports buffer writes,
// record checksums, the entry point and the write marks
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   req_cmd, req_text_char
//   rsp      out  rsp_valid/rsp_stall   kind, write offset/byte, sums, marks
//
// one character beat is taken every cycle while the queue has room; the result
// of a character passes through a queue entry, then the result register
// synchronous active-high reset; no clearing pass, the block is ready at once
// a stalled rsp beat holds; the four-entry operation queue absorbs the
// characters that arrive meanwhile and req_stall rises only when it is full
// a restart beat travels through the queue, so results queued ahead of it
// still carry the old marks
// ----------------------------------------------------------------------------
`default_nettype none

module srecord_stream_loader (
   input  wire logic                         clock,
   input  wire logic                         reset,

   // character input
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_cmd,
   input  wire logic [7:0]                   req_text_char,

   // result output
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [1:0]                        rsp_kind,
   output logic [ssl_pkg::BUF_BITS-1:0]      rsp_write_offset,
   output logic [7:0]                        rsp_write_byte,
   output logic [7:0]                        rsp_record_type,
   output logic [7:0]                        rsp_sum_calc,
   output logic [7:0]                        rsp_sum_recv,
   output logic                              rsp_sum_ok,
   output logic [31:0]                       rsp_entry_point,
   output logic [ssl_pkg::BUF_BITS-1:0]      rsp_low_mark,
   output logic [ssl_pkg::BUF_BITS:0]        rsp_high_mark,
   output logic                              rsp_end_length_bad,
   output logic [15:0]                       rsp_record_number
);

   logic             q_full;
   logic             take;
   logic             push_valid;
   ssl_pkg::op_type  push_op;
   logic             q_valid;
   ssl_pkg::op_type  q_op;
   logic             pop;
   ssl_pkg::rsp_type rsp;

   // a beat is taken whenever the queue has room
   assign req_stall = q_full;
   assign take      = req_valid && !q_full;

   // front: digit pairing and record phase tracking
   ssl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .cmd        (req_cmd),
      .text_char  (req_text_char),
      .push_valid (push_valid),
      .push_op    (push_op)
   );

   // queue of decoded operations
   ssl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .full       (q_full),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_op       (q_op)
   );

   // back: write pointer, marks, record count and result register
   ssl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_op      (q_op),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   // unpack the result beat onto its ports
   assign rsp_kind           = rsp.kind;
   assign rsp_write_offset   = rsp.write_offset;
   assign rsp_write_byte     = rsp.write_byte;
   assign rsp_record_type    = rsp.record_type;
   assign rsp_sum_calc       = rsp.sum_calc;
   assign rsp_sum_recv       = rsp.sum_recv;
   assign rsp_sum_ok         = rsp.sum_ok;
   assign rsp_entry_point    = rsp.entry_point;
   assign rsp_low_mark       = rsp.low_mark;
   assign rsp_high_mark      = rsp.high_mark;
   assign rsp_end_length_bad = rsp.end_length_bad;
   assign rsp_record_number  = rsp.record_number;

endmodule

`default_nettype wire

>>> tb/srecord_stream_loader_tb.sv
// ----------------------------------------------------------------------------
// srecord_stream_loader_tb: self-checking bench of the s-record stream loader
// a short directed table, then random record streams (s0, s3, s7, unknown
// types, noise, bad digits, restarts) under four idling phases; every result
// beat is checked field by field against an in-bench model of the loader
// ----------------------------------------------------------------------------
`default_nettype none

module srecord_stream_loader_tb;

   // scanner phases of the loader model
   typedef enum logic [2:0] {
      SEEK_S, SEEK_TYPE, IN_LEN, IN_ADDR, IN_BODY, IN_CSUM, HALTED
   } scan_phase_type;

   // one input beat of the plan
   typedef struct {
      bit         cmd;
      logic [7:0] ch;
   } beat_type;

   // directed row: kind and sum_ok typed in where pinned
   typedef struct {
      bit         cmd;
      logic [7:0] ch;
      bit         pin;
      logic [1:0] kind;
      bit         ok;
   } dir_row_type;

   localparam int ROWS        = 21;
   localparam int PHASE_BEATS = 350;     // beats per idling phase
   localparam int HOLD_CYCLES = 300;     // long receiver hold-off
   localparam int TAIL_CYCLES = 16;      // settling time after the last expected result

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_cmd;
   logic [7:0]                   req_text_char;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [1:0]                   rsp_kind;
   logic [ssl_pkg::BUF_BITS-1:0] rsp_write_offset;
   logic [7:0]                   rsp_write_byte;
   logic [7:0]                   rsp_record_type;
   logic [7:0]                   rsp_sum_calc;
   logic [7:0]                   rsp_sum_recv;
   logic                         rsp_sum_ok;
   logic [31:0]                  rsp_entry_point;
   logic [ssl_pkg::BUF_BITS-1:0] rsp_low_mark;
   logic [ssl_pkg::BUF_BITS:0]   rsp_high_mark;
   logic                         rsp_end_length_bad;
   logic [15:0]                  rsp_record_number;

   // pin info travels with the beat, driven like payload
   logic                         beat_pin;
   logic [1:0]                   beat_kind;
   logic                         beat_ok;

   // loader model state
   scan_phase_type               scan_phase;
   logic [3:0]                   hi_nib;
   logic                         nib_half;
   logic [7:0]                   pairs_todo;
   logic [2:0]                   addr_count;
   logic [31:0]                  addr_acc;
   logic [ssl_pkg::BUF_BITS-1:0] wr_ptr;
   logic [7:0]                   pair_sum;
   logic [7:0]                   rec_type;
   logic [ssl_pkg::BUF_BITS-1:0] low_wm;
   logic [ssl_pkg::BUF_BITS:0]   high_wm;
   logic [15:0]                  rec_count;
   logic                         digit_bad;
   logic [31:0]                  entry_addr;

   ssl_pkg::rsp_type             results_due [$];
   beat_type                     beat_plan [$];
   logic [7:0]                   frame_body [$];
   dir_row_type                  dir_rows [ROWS];

   int                           fail_count = 0;
   int                           req_idle_pct;
   int                           rsp_idle_pct;
   int                           hold_asked;  // bumped by the stimulus to ask for a hold-off
   int                           hold_seen;
   int                           hold_left;

   srecord_stream_loader i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_text_char      (req_text_char),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_write_offset   (rsp_write_offset),
      .rsp_write_byte     (rsp_write_byte),
      .rsp_record_type    (rsp_record_type),
      .rsp_sum_calc       (rsp_sum_calc),
      .rsp_sum_recv       (rsp_sum_recv),
      .rsp_sum_ok         (rsp_sum_ok),
      .rsp_entry_point    (rsp_entry_point),
      .rsp_low_mark       (rsp_low_mark),
      .rsp_high_mark      (rsp_high_mark),
      .rsp_end_length_bad (rsp_end_length_bad),
      .rsp_record_number  (rsp_record_number)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit, far above the slowest correct run
   initial begin
      #4000000;
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // loader model
   // ---------------------------------------------------------------------

   // hex digit value, -1 for anything else
   function automatic int hex_val(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   function automatic void clear_loader();
      scan_phase = SEEK_S;
      hi_nib     = '0;
      nib_half   = 1'b0;
      pairs_todo = '0;
      addr_count = '0;
      addr_acc   = '0;
      wr_ptr     = '0;
      pair_sum   = '0;
      rec_type   = '0;
      low_wm     = ssl_pkg::BUF_MASK;
      high_wm    = '0;
      rec_count  = 16'd1;
      digit_bad  = 1'b0;
      entry_addr = '0;
   endfunction

   // common part of every result: type, entry point, marks, record number
   function automatic ssl_pkg::rsp_type result_base(input logic [1:0] kind);
      ssl_pkg::rsp_type r;
      r               = '0;
      r.kind          = kind;
      r.record_type   = rec_type;
      r.entry_point   = entry_addr;
      r.low_mark      = low_wm;
      r.high_mark     = high_wm;
      r.record_number = rec_count;
      return r;
   endfunction

   // high mark takes in an end offset, capped at the buffer size
   function automatic void raise_high(input logic [ssl_pkg::BUF_BITS:0] end_ofs);
      if (end_ofs > ssl_pkg::BUF_SIZE) end_ofs = ssl_pkg::BUF_SIZE;
      if (end_ofs > high_wm) high_wm = end_ofs;
   endfunction

   // advance the model by one accepted beat; 1 when a result is due
   function automatic bit predict_beat(input bit cmd, input logic [7:0] c,
                                       output ssl_pkg::rsp_type r);
      int         v;
      logic [7:0] b;
      logic [7:0] calc;
      r = '0;
      if (cmd) begin
         clear_loader();
         return 1'b0;
      end
      case (scan_phase)
         SEEK_S: begin
            if (c == ssl_pkg::CHAR_S) begin
               pair_sum   = '0;
               digit_bad  = 1'b0;
               nib_half   = 1'b0;
               scan_phase = SEEK_TYPE;
            end
            return 1'b0;
         end
         SEEK_TYPE: begin
            rec_type   = c;
            scan_phase = IN_LEN;
            return 1'b0;
         end
         HALTED: return 1'b0;
         default: ;
      endcase

      v = hex_val(c);
      if (v < 0) begin
         digit_bad = 1'b1;
         v = 0;
      end
      if (!nib_half) begin
         hi_nib   = v[3:0];
         nib_half = 1'b1;
         return 1'b0;
      end
      nib_half = 1'b0;
      b = {hi_nib, v[3:0]};

      if (scan_phase == IN_CSUM) begin
         calc = ~pair_sum;
         r = result_base(rec_type == ssl_pkg::CHAR_S7 ? ssl_pkg::KIND_LOAD
                                                      : ssl_pkg::KIND_RECORD);
         r.sum_calc = calc;
         r.sum_recv = b;
         r.sum_ok   = (calc == b) && !digit_bad;
         if (rec_type == ssl_pkg::CHAR_S7) begin
            r.end_length_bad = (pairs_todo != 0);
            scan_phase = HALTED;
         end else begin
            scan_phase = SEEK_S;
         end
         rec_count++;
         return 1'b1;
      end

      pair_sum += b;

      if (scan_phase == IN_LEN) begin
         // a bad digit in the length stops the whole load
         if (digit_bad) begin
            r = result_base(ssl_pkg::KIND_ABORT);
            scan_phase = HALTED;
            return 1'b1;
         end
         if (rec_type == ssl_pkg::CHAR_ZERO) begin
            pairs_todo = (b > 0) ? b - 8'd1 : 8'd0;
            scan_phase = (pairs_todo != 0) ? IN_BODY : IN_CSUM;
         end else if (rec_type == ssl_pkg::CHAR_S3 || rec_type == ssl_pkg::CHAR_S7) begin
            addr_count = '0;
            addr_acc   = '0;
            if (rec_type == ssl_pkg::CHAR_S3) pairs_todo = (b > 5) ? b - 8'd5 : 8'd0;
            else                              pairs_todo = (b != 5) ? 8'd1 : 8'd0;
            scan_phase = IN_ADDR;
         end else begin
            // unknown type: next pair is the checksum
            scan_phase = IN_CSUM;
         end
         return 1'b0;
      end

      if (scan_phase == IN_ADDR) begin
         addr_acc   = {addr_acc[23:0], b};
         addr_count = addr_count + 3'd1;
         if (addr_count < 4) return 1'b0;
         if (rec_type == ssl_pkg::CHAR_S7) begin
            entry_addr = addr_acc;
            scan_phase = IN_CSUM;
            return 1'b0;
         end
         wr_ptr = addr_acc[ssl_pkg::BUF_BITS-1:0];
         if (wr_ptr < low_wm) low_wm = wr_ptr;
         raise_high({1'b0, wr_ptr});
         scan_phase = (pairs_todo != 0) ? IN_BODY : IN_CSUM;
         return 1'b0;
      end

      // body pair
      if (pairs_todo != 0) pairs_todo = pairs_todo - 8'd1;
      if (pairs_todo == 0) scan_phase = IN_CSUM;
      if (rec_type != ssl_pkg::CHAR_S3) return 1'b0;
      raise_high({1'b0, wr_ptr} + 1'b1);
      r = result_base(ssl_pkg::KIND_WRITE);
      r.write_offset = wr_ptr;
      r.write_byte   = b;
      wr_ptr = wr_ptr + 1'b1;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------

   function automatic void match(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // sample both channels at the edge; the model runs on accepted input beats
   always @(posedge clock) begin
      ssl_pkg::rsp_type want;
      ssl_pkg::rsp_type got;
      bit               due;
      if (reset) begin
         clear_loader();
      end else begin
         if (req_valid && !req_stall) begin
            due = predict_beat(req_cmd, req_text_char, want);
            if (beat_pin) begin
               // typed-in expectation overrides the model
               want.kind   = beat_kind;
               want.sum_ok = beat_ok;
               due = 1'b1;
            end
            if (due) results_due.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got.kind           = rsp_kind;
            got.write_offset   = rsp_write_offset;
            got.write_byte     = rsp_write_byte;
            got.record_type    = rsp_record_type;
            got.sum_calc       = rsp_sum_calc;
            got.sum_recv       = rsp_sum_recv;
            got.sum_ok         = rsp_sum_ok;
            got.entry_point    = rsp_entry_point;
            got.low_mark       = rsp_low_mark;
            got.high_mark      = rsp_high_mark;
            got.end_length_bad = rsp_end_length_bad;
            got.record_number  = rsp_record_number;
            if (results_due.size() == 0) begin
               $error("result beat with nothing expected, kind %0d", rsp_kind);
               fail_count++;
            end else begin
               want = results_due.pop_front();
               match("kind", want.kind, got.kind);
               match("write_offset", want.write_offset, got.write_offset);
               match("write_byte", want.write_byte, got.write_byte);
               match("record_type", want.record_type, got.record_type);
               match("sum_calc", want.sum_calc, got.sum_calc);
               match("sum_recv", want.sum_recv, got.sum_recv);
               match("sum_ok", want.sum_ok, got.sum_ok);
               match("entry_point", want.entry_point, got.entry_point);
               match("low_mark", want.low_mark, got.low_mark);
               match("high_mark", want.high_mark, got.high_mark);
               match("end_length_bad", want.end_length_bad, got.end_length_bad);
               match("record_number", want.record_number, got.record_number);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver: random stall, plus a long hold-off when the stimulus asks
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_seen <= 0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // stream planning
   // ---------------------------------------------------------------------

   function automatic void plan_char(input bit cmd, input logic [7:0] ch);
      beat_type nb;
      nb.cmd = cmd;
      nb.ch  = ch;
      beat_plan.push_back(nb);
   endfunction

   // hex digit in random case
   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      if (n < 10) return "0" + n;
      return ($urandom_range(1) ? "A" : "a") + (n - 4'd10);
   endfunction

   function automatic logic [7:0] junk_char();
      logic [7:0] c;
      do c = 8'($urandom); while (hex_val(c) >= 0);
      return c;
   endfunction

   // one hex pair, now and then with a bad digit in it
   function automatic void plan_byte(input logic [7:0] b);
      logic [7:0] c1;
      logic [7:0] c2;
      c1 = hex_digit(b[7:4]);
      c2 = hex_digit(b[3:0]);
      if ($urandom_range(59) == 0) begin
         if ($urandom_range(1)) c1 = junk_char();
         else                   c2 = junk_char();
      end
      plan_char(1'b0, c1);
      plan_char(1'b0, c2);
   endfunction

   // 'S', type, length, frame_body, checksum; a bad length is followed by a restart
   function automatic void plan_frame(input logic [7:0] tch, input logic [7:0] len,
                                      input bit bad_len);
      logic [7:0] sum;
      logic [7:0] c1;
      logic [7:0] c2;
      sum = len;
      plan_char(1'b0, ssl_pkg::CHAR_S);
      plan_char(1'b0, tch);
      c1 = hex_digit(len[7:4]);
      c2 = hex_digit(len[3:0]);
      if (bad_len) begin
         if ($urandom_range(1)) c1 = junk_char();
         else                   c2 = junk_char();
      end
      plan_char(1'b0, c1);
      plan_char(1'b0, c2);
      foreach (frame_body[i]) begin
         sum += frame_body[i];
         plan_byte(frame_body[i]);
      end
      if ($urandom_range(7) == 0) plan_byte(8'($urandom));
      else                        plan_byte(~sum);
      frame_body.delete();
      if (bad_len) plan_char(1'b1, 8'($urandom));
   endfunction

   function automatic void plan_record();
      int          roll;
      int          n;
      logic [7:0]  len;
      logic [7:0]  tch;
      logic [7:0]  gap;
      logic [31:0] addr;
      bit          bad_len;
      roll    = $urandom_range(99);
      bad_len = ($urandom_range(32) == 0);

      // line ends and other filler between records
      if ($urandom_range(9) < 3) begin
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(3))
               0: gap = 8'h0d;
               1: gap = 8'h0a;
               2: gap = " ";
               default: gap = 8'($urandom);
            endcase
            if (gap == ssl_pkg::CHAR_S) gap = 8'h0a;
            plan_char(1'b0, gap);
         end
      end

      if (roll < 5) begin
         plan_char(1'b1, 8'($urandom));
      end else if (roll < 48) begin
         // s3: address then data, addresses often near the buffer top to wrap
         n = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 5);
         addr = $urandom;
         case ($urandom_range(7))
            0, 1: addr[ssl_pkg::BUF_BITS-1:0] =
                     ssl_pkg::BUF_MASK - ssl_pkg::BUF_BITS'($urandom_range(0, 4));
            2:    addr[ssl_pkg::BUF_BITS-1:0] = '0;
            default: ;
         endcase
         for (int i = 3; i >= 0; i--) frame_body.push_back(addr[8*i +: 8]);
         repeat (n) frame_body.push_back(8'($urandom));
         len = 8'(n + 5);
         if ($urandom_range(9) == 0) len = 8'($urandom_range(0, 6));
         if ($urandom_range(39) == 0) len = 8'($urandom);
         plan_frame(ssl_pkg::CHAR_S3, len, bad_len);
      end else if (roll < 62) begin
         // s0: header text, discarded
         n = $urandom_range(0, 5);
         repeat (n) frame_body.push_back(8'($urandom));
         len = 8'(n + 1);
         if ($urandom_range(9) == 0) len = 8'd0;
         if ($urandom_range(39) == 0) len = 8'($urandom);
         plan_frame(ssl_pkg::CHAR_ZERO, len, bad_len);
      end else if (roll < 76) begin
         // s7: entry point, ends the load, so restart afterwards
         addr = $urandom;
         if ($urandom_range(5) == 0) addr = '1;
         for (int i = 3; i >= 0; i--) frame_body.push_back(addr[8*i +: 8]);
         len = 8'd5;
         if ($urandom_range(4) == 0) len = 8'($urandom_range(0, 8));
         plan_frame(ssl_pkg::CHAR_S7, len, bad_len);
         if (!bad_len) plan_char(1'b1, 8'($urandom));
      end else if (roll < 90) begin
         // unknown type: length then checksum
         do tch = 8'($urandom);
         while (tch == ssl_pkg::CHAR_ZERO || tch == ssl_pkg::CHAR_S3 ||
                tch == ssl_pkg::CHAR_S7);
         plan_frame(tch, 8'($urandom), bad_len);
      end else begin
         // raw noise, an 'S' in here may throw the parse off
         repeat ($urandom_range(1, 6)) plan_char(1'b0, 8'($urandom));
      end
   endfunction

   // ---------------------------------------------------------------------
   // sender: random idle cycles, beat held until accepted
   // ---------------------------------------------------------------------
   task automatic send_beat(input bit cmd, input logic [7:0] ch, input bit pin,
                            input logic [1:0] kind, input bit ok);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_text_char <= ch;
      beat_pin      <= pin;
      beat_kind     <= kind;
      beat_ok       <= ok;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      int       target;
      int       sent;
      beat_type nb;
      req_valid     = 1'b0;
      req_cmd       = 1'b0;
      req_text_char = '0;
      beat_pin      = 1'b0;
      beat_kind     = ssl_pkg::KIND_WRITE;
      beat_ok       = 1'b0;
      req_idle_pct  = 0;
      rsp_idle_pct  = 0;
      hold_asked    = 0;
      reset         = 1'b1;

      // restart with all-ones char, hunt skips, unknown type with good and
      // bad checksum digit, bad length digit, chars ignored after abort
      dir_rows = '{
         '{1'b1, 8'hff, 1'b0, ssl_pkg::KIND_WRITE,  1'b0},
         '{1'b0, 8'h00, 1'b0, ssl_pkg::KIND_WRITE,  1'b0},
         '{1'b0, "S",   1'b0, ssl_pkg::KIND_WRITE,  1'b0},
         '{1'b0, "5",   1'b0, ssl_pkg::KIND_WRITE,  1'b0},
         '{1'b0, "0",   1'b0, ssl_pkg::KIND_WRITE,  1'b0},
         '{1'b0, "3",   1'b0, ssl_pkg::KIND_WRITE,  1'b0},
         '{1'b0, "F",   1'b0, ssl_pkg::KIND_WRITE,  1'b0},
         '{1'b0, "c",   1'b1, ssl_pkg::KIND_RECORD, 1'b1},
         '{1'b0, "S",   1'b0, ssl_pkg::KIND_WRITE,  1'b0},
         '{1'b0, "5",   1'b0, ssl_pkg::KIND_WRITE,  1'b0},
         '{1'b0, "0",   1'b0, ssl_pkg::KIND_WRITE,  1'b0},
         '{1'b0, "3",   1'b0, ssl_pkg::KIND_WRITE,  1'b0},
         '{1'b0, "F",   1'b0, ssl_pkg::KIND_WRITE,  1'b0},
         '{1'b0, "G",   1'b1, ssl_pkg::KIND_RECORD, 1'b0},
         '{1'b0, "S",   1'b0, ssl_pkg::KIND_WRITE,  1'b0},
         '{1'b0, "7",   1'b0, ssl_pkg::KIND_WRITE,  1'b0},
         '{1'b0, "Z",   1'b0, ssl_pkg::KIND_WRITE,  1'b0},
         '{1'b0, "0",   1'b1, ssl_pkg::KIND_ABORT,  1'b0},
         '{1'b0, "S",   1'b0, ssl_pkg::KIND_WRITE,  1'b0},
         '{1'b1, "S",   1'b0, ssl_pkg::KIND_WRITE,  1'b0},
         '{1'b0, 8'h80, 1'b0, ssl_pkg::KIND_WRITE,  1'b0}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[k])
         send_beat(dir_rows[k].cmd, dir_rows[k].ch, dir_rows[k].pin,
                   dir_rows[k].kind, dir_rows[k].ok);

      // long receiver hold-off while the sender keeps going at full rate
      hold_asked++;

      // idling phases: none, sender 71, receiver 71, both 24
      target = 0;
      sent   = 0;
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin req_idle_pct = 0;  rsp_idle_pct = 0;  end
            1: begin req_idle_pct = 71; rsp_idle_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_idle_pct = 71; end
            default: begin req_idle_pct = 24; rsp_idle_pct = 24; end
         endcase
         target += PHASE_BEATS;
         while (sent < target) begin
            if (beat_plan.size() == 0) plan_record();
            nb = beat_plan.pop_front();
            send_beat(nb.cmd, nb.ch, 1'b0, ssl_pkg::KIND_WRITE, 1'b0);
            sent++;
         end
      end
      req_valid <= 1'b0;

      // drain, then let the pipeline settle
      while (results_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
